FILE: rtl/lcrb_pkg.sv
`default_nettype none

package lcrb_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = (ADDR_W > 8) ? ADDR_W : 8;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_POP     = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] pop_data;
        logic [7:0] fill_length;
        logic       line_complete;
    } out_t;

    typedef logic [ADDR_W-1:0] addr_t;

    function automatic addr_t next_index(input addr_t i);
        addr_t r;
        if (i == addr_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + addr_t'(1);
        end
        return r;
    endfunction

    // (tail - head) mod DEPTH, low 8 bits
    function automatic logic [7:0] fill_of(input addr_t head, input addr_t tail);
        logic [FILL_W-1:0] h;
        logic [FILL_W-1:0] t;
        logic [FILL_W-1:0] f;
        h = FILL_W'(head);
        t = FILL_W'(tail);
        if (t >= h)
        begin
            f = t - h;
        end
        else
        begin
            f = t + FILL_W'(DEPTH) - h;
        end
        return f[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lcrb_ram.sv
`default_nettype none

module lcrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/line_command_ring_buffer.sv
// Receive-side command line buffer.
// in channel (in_valid/in_ready/in_data) carries one request: op selects
// receive byte, pop oldest byte or clear command; rx_byte is the byte for a
// receive. Received bytes go to the tail of a 256-entry circular store until
// a CR followed by LF has been stored; after that bytes are dropped until a
// clear, which also empties the store (head := tail).
// out channel (out_valid/out_ready/out_data) returns exactly one result per
// request: popped byte (0 if not a pop), fill length and the complete flag.
// Receive, clear and no-op results appear the cycle after accept; a pop
// result passes the registered read port of the store, then the output
// register. One request per cycle for receive/clear while the receiver
// keeps up; a pop blocks requests until its result is registered. A new
// request is taken in the cycle the pending result drains. Reset clears
// head, tail, previous byte, complete flag and the output valid flag;
// store contents are undefined until written. A stalled receiver holds
// the result and blocks further requests; no request or result is lost.
`default_nettype none

module line_command_ring_buffer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_ready,
    input  wire lcrb_pkg::in_t in_data,
    output      logic          out_valid,
    input  wire logic          out_ready,
    output      lcrb_pkg::out_t out_data
);

    import lcrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    addr_t      head_reg, head_next;
    addr_t      tail_reg, tail_next;
    logic [7:0] prev_reg, prev_next;
    logic       complete_reg, complete_next;
    logic       out_valid_reg, out_valid_next;
    out_t       out_reg, out_next;

    logic       accept;
    logic       drain;
    logic       ram_we;
    logic       ram_re;
    logic [7:0] ram_rdata;

    assign drain    = out_valid_reg && out_ready;
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign ram_we = accept && (in_data.op == OP_RECEIVE) && !complete_reg;
    assign ram_re = accept && (in_data.op == OP_POP);

    lcrb_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(in_data.rx_byte),
        .re   (ram_re),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        prev_next      = prev_reg;
        complete_next  = complete_reg;
        out_valid_next = out_valid_reg && !drain;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique if (in_data.op == OP_RECEIVE)
                    begin
                        if (!complete_reg)
                        begin
                            if (in_data.rx_byte == CHAR_LF && prev_reg == CHAR_CR)
                            begin
                                complete_next = 1'b1;
                            end
                            tail_next = next_index(tail_reg);
                        end
                        prev_next = in_data.rx_byte;
                    end
                    else if (in_data.op == OP_POP)
                    begin
                        // result waits for the store read
                        head_next  = next_index(head_reg);
                        state_next = ST_READ;
                    end
                    else if (in_data.op == OP_CLEAR)
                    begin
                        complete_next = 1'b0;
                        head_next     = tail_reg;
                    end
                    else
                    begin
                        // unused code: report state unchanged
                    end

                    if (in_data.op != OP_POP)
                    begin
                        out_valid_next         = 1'b1;
                        out_next.pop_data      = '0;
                        out_next.fill_length   = fill_of(head_next, tail_next);
                        out_next.line_complete = complete_next;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next         = 1'b1;
                out_next.pop_data      = ram_rdata;
                out_next.fill_length   = fill_of(head_reg, tail_reg);
                out_next.line_complete = complete_reg;
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            prev_reg      <= '0;
            complete_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            prev_reg      <= prev_next;
            complete_reg  <= complete_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_read_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("output register occupied during store read");

    a_pop_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.op == OP_POP) |=> (state_reg == ST_READ))
        else $error("pop did not start a store read");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("store read did not produce a result");

    a_complete_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(complete_reg) |-> $past(accept && in_data.op == OP_RECEIVE
                                      && in_data.rx_byte == CHAR_LF
                                      && prev_reg == CHAR_CR))
        else $error("complete flag set without CR LF");

    a_no_store_when_complete: assert property (@(posedge clk) disable iff (!rst_n)
        complete_reg |-> !ram_we)
        else $error("byte stored while command complete");

endmodule

`default_nettype wire
